// ===== hdl/tmcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Operation codes, character codes, cell constants and sequencer states.
// ----------------------------------------------------------------------------
package tmcw_pkg;

	localparam logic [2:0] OP_PRINT  = 3'd0;
	localparam logic [2:0] OP_CLEAR  = 3'd1;
	localparam logic [2:0] OP_CURSOR = 3'd2;
	localparam logic [2:0] OP_PUT    = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_RETURN    = 8'h0D;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	localparam logic [7:0]  CLEAR_ATTR = 8'h0F;
	localparam logic [15:0] CLEAR_CELL = {CLEAR_ATTR, CH_SPACE};

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_CLEAR,
		S_SCROLL,
		S_SDRAIN,
		S_ADDR,
		S_MEM,
		S_LIN,
		S_OUT
	} tmcw_state_t;

endpackage

// ===== hdl/tmcw_lin_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear position unit
// Registered row times width plus column, shared by cell addressing and the
// cursor position output.
// ----------------------------------------------------------------------------
module tmcw_lin_unit #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                    clk,
	input  logic [$clog2(ROWS)-1:0]                 row,
	input  logic [$clog2(COLUMNS+1)-1:0]            col,
	output logic [$clog2(COLUMNS*ROWS+1)-1:0]       lin_q
);

	localparam int LIN_W = $clog2(COLUMNS*ROWS+1);

	always_ff @(posedge clk) begin
		lin_q <= LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col);
	end

endmodule

// ===== hdl/text_mode_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text mode console writer
// Screen store of COLUMNS x ROWS character cells with a cursor, driven by
// print, clear, set cursor, put and read transactions.
//
// Usage:
//   Input and output channels use valid and stall; a transaction completes
//   on a rising edge with valid high and stall low. One output transaction
//   follows every input transaction, in order.
//   in_stall is low only while the sequencer is idle; one transaction is in
//   work at a time. Cursor moves and out-of-range requests pass S_EXEC,
//   S_LIN and S_OUT; cell writes and reads pass S_EXEC, S_ADDR, S_MEM and
//   S_OUT, as S_ADDR feeds the shared position unit and S_MEM the store.
//   With a free output the result is loaded in S_OUT, and the next input
//   transaction is taken in the cycle after that. A clear sweeps the store.
//   A scroll copies and blanks through the store.
//   After reset the store is swept to blank cells before the first input
//   transaction is taken; cfg_wr_en is honoured then.
//   A stalled output holds; a finished result waits in the output register
//   while the next input transaction may already be accepted.
// ----------------------------------------------------------------------------
module text_mode_console_writer
	import tmcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [7:0]  char_code,
	input  logic [7:0]  pos_x,
	input  logic [5:0]  pos_y,
	input  logic [3:0]  attr_fg,
	input  logic [3:0]  attr_bg,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  cursor_col,
	output logic [4:0]  cursor_row,
	output logic [10:0] cursor_linear,
	output logic [15:0] cell_word,
	output logic        status
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int COL_W  = $clog2(COLUMNS + 1);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int LIN_W  = $clog2(CELLS + 1);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int PTR_W  = $clog2(CELLS + COLUMNS);

	tmcw_state_t state_q, state_d;

	logic [15:0] mem [CELLS];

	logic [7:0]       attr_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [PTR_W-1:0] ptr_q;
	logic             out_valid_q;
	logic             wv_s1;

	logic [2:0]        op_q;
	logic [7:0]        ch_q;
	logic [7:0]        px_q;
	logic [5:0]        py_q;
	logic [3:0]        fg_q;
	logic [3:0]        bg_q;
	logic [COL_W-1:0]  tgt_col_q;
	logic [ROW_W-1:0]  tgt_row_q;
	logic [15:0]       wdata_q;
	logic              write_q;
	logic              read_q;
	logic              pend_q;
	logic              status_q;
	logic [ADDR_W-1:0] dst_s1;
	logic              blank_s1;
	logic [15:0]       rd_data_q;

	logic [6:0]  out_col_q;
	logic [4:0]  out_row_q;
	logic [10:0] out_lin_q;
	logic [15:0] out_cell_q;
	logic        out_status_q;

	logic [ROW_W-1:0] unit_row;
	logic [COL_W-1:0] unit_col;
	logic [LIN_W-1:0] lin_q;

	logic              in_accept;
	logic              out_free;
	logic              in_range;
	logic              sweep_last;
	logic              scroll_last;
	logic [15:0]       blank_cell;

	tmcw_state_t      ex_next;
	logic [COL_W-1:0] ex_col;
	logic [ROW_W-1:0] ex_row;
	logic [COL_W-1:0] ex_tgt_col;
	logic [ROW_W-1:0] ex_tgt_row;
	logic [15:0]      ex_wdata;
	logic             ex_write;
	logic             ex_read;
	logic             ex_pend;
	logic             ex_status;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [15:0]       mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;

	assign in_accept   = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign blank_cell  = {attr_q, CH_SPACE};
	assign sweep_last  = (ptr_q == PTR_W'(CELLS - 1));
	assign scroll_last = (ptr_q == PTR_W'(CELLS + COLUMNS - 1));
	assign in_range    = ({1'b0, px_q} < 9'(COLUMNS)) && ({1'b0, py_q} < 7'(ROWS));

	assign unit_row = (state_q == S_ADDR) ? tgt_row_q : row_q;
	assign unit_col = (state_q == S_ADDR) ? tgt_col_q : col_q;

	tmcw_lin_unit #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_lin (
		.clk  (clk),
		.row  (unit_row),
		.col  (unit_col),
		.lin_q(lin_q)
	);

	always_comb begin
		ex_next    = S_LIN;
		ex_col     = col_q;
		ex_row     = row_q;
		ex_tgt_col = col_q;
		ex_tgt_row = row_q;
		ex_wdata   = blank_cell;
		ex_write   = 1'b0;
		ex_read    = 1'b0;
		ex_pend    = 1'b0;
		ex_status  = 1'b0;
		case (op_q)
			OP_PRINT: begin
				if (ch_q == CH_NEWLINE) begin
					ex_col = '0;
					if (row_q < ROW_W'(ROWS - 1)) begin
						ex_row = row_q + ROW_W'(1);
					end else begin
						ex_next = S_SCROLL;
					end
				end else if (ch_q == CH_RETURN) begin
					ex_col = '0;
				end else if (ch_q == CH_BACKSPACE) begin
					if (col_q != '0) begin
						ex_col     = col_q - COL_W'(1);
						ex_tgt_col = col_q - COL_W'(1);
						ex_write   = 1'b1;
						ex_next    = S_ADDR;
					end else if (row_q != '0) begin
						ex_row     = row_q - ROW_W'(1);
						ex_col     = COL_W'(COLUMNS - 1);
						ex_tgt_row = row_q - ROW_W'(1);
						ex_tgt_col = COL_W'(COLUMNS - 1);
						ex_write   = 1'b1;
						ex_next    = S_ADDR;
					end
				end else begin
					ex_wdata = {attr_q, ch_q};
					ex_write = 1'b1;
					if (col_q >= COL_W'(COLUMNS)) begin
						ex_col     = COL_W'(1);
						ex_tgt_col = '0;
						if (row_q < ROW_W'(ROWS - 1)) begin
							ex_row     = row_q + ROW_W'(1);
							ex_tgt_row = row_q + ROW_W'(1);
							ex_next    = S_ADDR;
						end else begin
							ex_pend = 1'b1;
							ex_next = S_SCROLL;
						end
					end else begin
						ex_col  = col_q + COL_W'(1);
						ex_next = S_ADDR;
					end
				end
			end
			OP_CLEAR: begin
				ex_col  = '0;
				ex_row  = '0;
				ex_next = S_CLEAR;
			end
			OP_CURSOR: begin
				if (in_range) begin
					ex_col = COL_W'(px_q);
					ex_row = ROW_W'(py_q);
				end else begin
					ex_status = 1'b1;
				end
			end
			OP_PUT: begin
				if (in_range) begin
					ex_tgt_col = COL_W'(px_q);
					ex_tgt_row = ROW_W'(py_q);
					ex_wdata   = {bg_q, fg_q, ch_q};
					ex_write   = 1'b1;
					ex_next    = S_ADDR;
				end else begin
					ex_status = 1'b1;
				end
			end
			OP_READ: begin
				if (in_range) begin
					ex_tgt_col = COL_W'(px_q);
					ex_tgt_row = ROW_W'(py_q);
					ex_read    = 1'b1;
					ex_next    = S_ADDR;
				end else begin
					ex_status = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT:   if (sweep_last) state_d = S_IDLE;
			S_IDLE:   if (in_accept) state_d = S_EXEC;
			S_EXEC:   state_d = ex_next;
			S_CLEAR:  if (sweep_last) state_d = S_LIN;
			S_SCROLL: if (scroll_last) state_d = S_SDRAIN;
			S_SDRAIN: state_d = pend_q ? S_ADDR : S_LIN;
			S_ADDR:   state_d = S_MEM;
			S_MEM:    state_d = S_OUT;
			S_LIN:    state_d = S_OUT;
			S_OUT:    if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != S_IDLE);
		mem_we    = 1'b0;
		mem_waddr = ptr_q[ADDR_W-1:0];
		mem_wdata = CLEAR_CELL;
		mem_re    = 1'b0;
		mem_raddr = ptr_q[ADDR_W-1:0];
		if (wv_s1) begin
			mem_we    = 1'b1;
			mem_waddr = dst_s1;
			mem_wdata = blank_s1 ? blank_cell : rd_data_q;
		end
		case (state_q)
			S_INIT, S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_SCROLL: begin
				mem_re = (ptr_q < PTR_W'(CELLS));
			end
			S_MEM: begin
				mem_we    = write_q;
				mem_waddr = lin_q[ADDR_W-1:0];
				mem_wdata = wdata_q;
				mem_re    = read_q;
				mem_raddr = lin_q[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			attr_q      <= CLEAR_ATTR;
			col_q       <= '0;
			row_q       <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
			wv_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				attr_q <= cfg_wr_data;
			end
			wv_s1 <= (state_q == S_SCROLL);
			if (state_q == S_EXEC) begin
				col_q <= ex_col;
				row_q <= ex_row;
				ptr_q <= (ex_next == S_SCROLL) ? PTR_W'(COLUMNS) : '0;
			end else if (state_q == S_INIT || state_q == S_CLEAR || state_q == S_SCROLL) begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q <= opcode;
			ch_q <= char_code;
			px_q <= pos_x;
			py_q <= pos_y;
			fg_q <= attr_fg;
			bg_q <= attr_bg;
		end
		if (state_q == S_EXEC) begin
			tgt_col_q <= ex_tgt_col;
			tgt_row_q <= ex_tgt_row;
			wdata_q   <= ex_wdata;
			write_q   <= ex_write;
			read_q    <= ex_read;
			pend_q    <= ex_pend;
			status_q  <= ex_status;
		end
		dst_s1   <= ADDR_W'(ptr_q - PTR_W'(COLUMNS));
		blank_s1 <= (ptr_q >= PTR_W'(CELLS));
		if (state_q == S_OUT && out_free) begin
			out_col_q    <= 7'(col_q);
			out_row_q    <= 5'(row_q);
			out_lin_q    <= 11'(lin_q);
			out_cell_q   <= read_q ? rd_data_q : 16'h0000;
			out_status_q <= status_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign cursor_col    = out_col_q;
	assign cursor_row    = out_row_q;
	assign cursor_linear = out_lin_q;
	assign cell_word     = out_cell_q;
	assign status        = out_status_q;

	// The cursor never leaves the screen; the column may sit one past the end.
	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= COL_W'(COLUMNS)) && (row_q < ROW_W'(ROWS)))
		else $error("cursor outside the screen");

	// Scroll writes are only in flight while the scroll walks or drains the store.
	a_scroll_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		wv_s1 |-> (state_q == S_SCROLL || state_q == S_SDRAIN))
		else $error("scroll write outside a scroll");

	// An accepted transaction is decoded in the next cycle.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == S_EXEC))
		else $error("accepted transaction not decoded");

	// A rejected position never returns cell data.
	a_status_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q) |-> (out_cell_q == 16'h0000))
		else $error("cell data returned with error status");

endmodule
